>>> hdl/shs_pkg.sv
// shared types, constants and round-constant table for the sha-256 stream hasher
// no dependencies; imported by every module of the block
package shs_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = 61;
	localparam int unsigned FillW  = 6;
	localparam int unsigned RoundW = 6;

	localparam logic [FillW-1:0] FillLast = 6'd63;
	localparam logic [FillW-1:0] FillLen  = 6'd56;
	localparam logic [RoundW-1:0] RoundLast = 6'd63;
	localparam logic [7:0] PadMark = 8'h80;

	// input request and result payloads
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} digest_t;

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARK,
		SRC_ZERO,
		SRC_LENGTH
	} byte_src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_COMP_INIT,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              push;
		byte_src_t         src;
		logic              init_work;
		logic              round;
		logic              final_add;
		logic              reinit;
		logic [RoundW-1:0] round_idx;
		logic [2:0]        word_idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FillW-1:0] fill;
	} status_t;

	typedef logic [WordW-1:0] word_t;

	function automatic word_t init_h(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = 32'h6A09E667;
			3'd1: r = 32'hBB67AE85;
			3'd2: r = 32'h3C6EF372;
			3'd3: r = 32'hA54FF53A;
			3'd4: r = 32'h510E527F;
			3'd5: r = 32'h9B05688C;
			3'd6: r = 32'h1F83D9AB;
			default: r = 32'h5BE0CD19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [RoundW-1:0] t);
		word_t r;
		case (t)
			6'd0:  r = 32'h428A2F98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hB5C0FBCF; 6'd3:  r = 32'hE9B5DBA5;
			6'd4:  r = 32'h3956C25B; 6'd5:  r = 32'h59F111F1;
			6'd6:  r = 32'h923F82A4; 6'd7:  r = 32'hAB1C5ED5;
			6'd8:  r = 32'hD807AA98; 6'd9:  r = 32'h12835B01;
			6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
			6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE;
			6'd14: r = 32'h9BDC06A7; 6'd15: r = 32'hC19BF174;
			6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
			6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC;
			6'd20: r = 32'h2DE92C6F; 6'd21: r = 32'h4A7484AA;
			6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
			6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D;
			6'd26: r = 32'hB00327C8; 6'd27: r = 32'hBF597FC7;
			6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
			6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27B70A85; 6'd33: r = 32'h2E1B2138;
			6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
			6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB;
			6'd38: r = 32'h81C2C92E; 6'd39: r = 32'h92722C85;
			6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
			6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3;
			6'd44: r = 32'hD192E819; 6'd45: r = 32'hD6990624;
			6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
			6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08;
			6'd50: r = 32'h2748774C; 6'd51: r = 32'h34B0BCB5;
			6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
			6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3;
			6'd56: r = 32'h748F82EE; 6'd57: r = 32'h78A5636F;
			6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
			6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB;
			6'd62: r = 32'hBEF9A3F7;
			default: r = 32'hC67178F2;
		endcase
		return r;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

endpackage

>>> hdl/shs_datapath.sv
// datapath: byte packer, 16-word schedule window, round logic and chaining words
// depends on shs_pkg
module shs_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  shs_pkg::cmd_t   cmd,
	input  logic [7:0]      in_byte,
	output shs_pkg::status_t status,
	output shs_pkg::word_t  h_word
);
	import shs_pkg::*;

	word_t             h_q [8];
	word_t             v_q [8];
	word_t             w_q [16];
	logic [23:0]       acc_q;
	logic [FillW-1:0]  fill_q;
	logic [CountW-1:0] count_q;

	logic [7:0]  push_byte;
	logic [63:0] len_bits;
	word_t       new_w, s0, s1, t1, t2, sig0, sig1, ch, maj;

	// padding byte source
	assign len_bits = {count_q, 3'b000};
	always_comb begin
		case (cmd.src)
			SRC_INPUT:  push_byte = in_byte;
			SRC_MARK:   push_byte = PadMark;
			SRC_ZERO:   push_byte = 8'h00;
			SRC_LENGTH: push_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
			default:    push_byte = 8'h00;
		endcase
	end

	// schedule expansion and round function
	always_comb begin
		s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		new_w = w_q[0] + s0 + w_q[9] + s1;
		sig1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		sig0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1   = v_q[7] + sig1 + ch + round_k(cmd.round_idx) + w_q[0];
		t2   = sig0 + maj;
	end

	// fill and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
		end else if (cmd.reinit) begin
			fill_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			fill_q <= fill_q + 1'b1;
			if (cmd.src == SRC_INPUT) count_q <= count_q + 1'b1;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else if (cmd.reinit) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else if (cmd.final_add) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	// working variables, window and byte packer
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (fill_q[1:0] == 2'b11) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= {acc_q, push_byte};
			end else begin
				acc_q <= {acc_q[15:0], push_byte};
			end
		end
		if (cmd.init_work) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= new_w;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign status.fill = fill_q;
	assign h_word      = h_q[cmd.word_idx];

endmodule

>>> hdl/shs_ctrl.sv
// controller: sequences byte intake, padding, the 64 rounds and digest output
// depends on shs_pkg
module shs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              has_byte,
	input  logic              end_of_message,
	input  logic              digest_stall,
	input  shs_pkg::status_t  status,
	output logic              item_stall,
	output logic              digest_valid,
	output shs_pkg::cmd_t     cmd
);
	import shs_pkg::*;

	state_t            state_q, state_d, ret_q, ret_d;
	logic [RoundW-1:0] round_q;
	logic [2:0]        word_q;
	logic              wrap;

	assign wrap = (status.fill == FillLast);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (has_byte && wrap) begin
						state_d = ST_COMP_INIT;
						ret_d   = end_of_message ? ST_PAD_MARK : ST_IDLE;
					end else if (end_of_message) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				if (wrap) begin
					state_d = ST_COMP_INIT;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (status.fill == FillLen) begin
					state_d = ST_PAD_LEN;
				end else if (wrap) begin
					state_d = ST_COMP_INIT;
					ret_d   = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (wrap) begin
					state_d = ST_COMP_INIT;
					ret_d   = ST_OUT;
				end
			end
			ST_COMP_INIT: state_d = ST_ROUND;
			ST_ROUND: begin
				if (round_q == RoundLast) state_d = ST_FINAL;
			end
			ST_FINAL: state_d = ret_q;
			ST_OUT: begin
				if (!digest_stall && word_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd           = '0;
		cmd.src       = SRC_INPUT;
		cmd.round_idx = round_q;
		cmd.word_idx  = word_q;
		item_stall    = 1'b1;
		digest_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.push   = item_valid && has_byte;
			end
			ST_PAD_MARK: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_MARK;
			end
			ST_PAD_ZERO: begin
				cmd.push = (status.fill != FillLen);
				cmd.src  = SRC_ZERO;
			end
			ST_PAD_LEN: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LENGTH;
			end
			ST_COMP_INIT: cmd.init_work = 1'b1;
			ST_ROUND:     cmd.round     = 1'b1;
			ST_FINAL:     cmd.final_add = 1'b1;
			ST_OUT: begin
				digest_valid = 1'b1;
				cmd.reinit   = !digest_stall && word_q == 3'd7;
			end
			default: ;
		endcase
	end

	// state, return point, round and word counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == ST_COMP_INIT) round_q <= '0;
			else if (state_q == ST_ROUND) round_q <= round_q + 1'b1;
			if (state_q == ST_OUT && !digest_stall) word_q <= word_q + 1'b1;
		end
	end

endmodule

>>> hdl/sha256_stream_hasher_unit.sv
// top level of the sha-256 stream hasher: controller plus datapath
// depends on shs_pkg, shs_ctrl, shs_datapath
//
// Takes one message byte per request while requests are not stalled. Each 64th byte
// starts a compression (load, 64 rounds at one round per cycle, chaining add), during
// which requests are stalled. An end-of-message request then costs the padding bytes
// up to the block end, with one turnaround state before the length bytes, one or two
// compressions, and eight digest words, one per accepted result, most significant
// first. The round unit is the limit on rate.
module sha256_stream_hasher_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  shs_pkg::item_t  item,
	output logic            digest_valid,
	input  logic            digest_stall,
	output shs_pkg::digest_t digest
);
	import shs_pkg::*;

	cmd_t    cmd;
	status_t status;
	word_t   h_word;

	shs_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.has_byte       (item.has_byte),
		.end_of_message (item.end_of_message),
		.digest_stall   (digest_stall),
		.status         (status),
		.item_stall     (item_stall),
		.digest_valid   (digest_valid),
		.cmd            (cmd)
	);

	shs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.in_byte(item.data_byte),
		.status (status),
		.h_word (h_word)
	);

	// result payload
	assign digest.digest_word = h_word;
	assign digest.word_number = cmd.word_idx;
	assign digest.last_word   = (cmd.word_idx == 3'd7);

endmodule

>>> hdl/shs_checker.sv
// port-level checks on digest word ordering and request stalling
// depends on shs_pkg; bound to sha256_stream_hasher_unit
module shs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             digest_valid,
	input logic             digest_stall,
	input shs_pkg::digest_t digest
);
	import shs_pkg::*;

	// last flag only on word seven
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.last_word == (digest.word_number == 3'd7)))
		else $error("last_word mismatch");

	// words follow one another without gaps
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && !digest.last_word) |=>
		(digest_valid && digest.word_number == $past(digest.word_number) + 3'd1))
		else $error("digest word out of order");

	// no request taken while the digest is going out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> item_stall)
		else $error("request accepted during digest output");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_stall) |=> (digest_valid && $stable(digest)))
		else $error("stalled result changed");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest       (digest)
);
